// ===== hdl/axis_calibrate_deadzone_debounce_assert.svh =====
// Assertion macros shared by the checker files of the axis calibration block.
// The enclosing scope must provide clk and rst.
`ifndef AXIS_CALIBRATE_DEADZONE_DEBOUNCE_ASSERT_SVH
`define AXIS_CALIBRATE_DEADZONE_DEBOUNCE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ACDD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ACDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/acdd_pkg.sv =====
`default_nettype none
package acdd_pkg;

  localparam int VALW = 16;
  localparam int OPW  = 19;             // signed operand width, holds +/-2*65535
  localparam int MAGW = OPW - 1;        // magnitude of a signed operand
  localparam int NUMW = MAGW + VALW;    // dividend magnitude
  localparam int DENW = MAGW;           // divisor magnitude
  localparam int CNTW = $clog2(NUMW + 1);
  localparam int SUMW = NUMW + 2;       // signed offset plus quotient

  localparam logic [VALW-1:0] HALF_SCALE = 16'd32767;
  localparam logic [VALW-1:0] FULL_SCALE = 16'd65535;
  localparam logic [VALW-1:0] HALF_UP    = 16'd32768;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RANGE_MIN      = 3'd0;
  localparam logic [2:0] CFG_RANGE_MAX      = 3'd1;
  localparam logic [2:0] CFG_CENTER_VALUE   = 3'd2;
  localparam logic [2:0] CFG_DEADZONE_WIDTH = 3'd3;
  localparam logic [2:0] CFG_DEBOUNCE_MS    = 3'd4;
  localparam logic [2:0] CFG_PRESSED_VALUE  = 3'd5;
  localparam logic [2:0] CFG_RELEASED_VALUE = 3'd6;
  localparam logic [2:0] CFG_MODE_FLAGS     = 3'd7;

  // Bits of mode_flags.
  localparam int MODE_TRIGGER  = 0;
  localparam int MODE_BUTTON   = 1;
  localparam int MODE_RELEASED = 2;
  localparam int MODE_PEAK     = 3;
  localparam int MODE_DEBOUNCE = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } acdd_state_t;

  // Output span of the linear map.
  typedef enum logic [1:0] {
    SPAN_FULL,
    SPAN_HALF_LO,
    SPAN_HALF_UP
  } acdd_span_t;

endpackage
`default_nettype wire

// ===== hdl/acdd_div.sv =====
`default_nettype none
module acdd_div import acdd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [NUMW-1:0] numq;
  logic [DENW-1:0] rem;
  logic [DENW:0]   rem_sh;
  logic [DENW:0]   diff;
  logic            fits;

  // One restoring step per cycle: shift in the next dividend bit and subtract
  // the divisor when it fits. The dividend register fills with the quotient.
  always_comb begin
    rem_sh = {rem, numq[NUMW-1]};
    diff   = rem_sh - {1'b0, den};
    fits   = !diff[DENW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Done rises for one cycle right after the last step.
      done <= busy && !start && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NUMW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numq <= num;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[DENW-1:0] : rem_sh[DENW-1:0];
      numq <= {numq[NUMW-2:0], fits};
    end
  end

  assign quo = numq;

endmodule
`default_nettype wire

// ===== hdl/axis_calibrate_deadzone_debounce.sv =====
`default_nettype none
// Axis calibration with deadzone, peak hold and return-to-center debounce.
// The input channel (in_valid / in_stall) carries one poll per beat: raw
// sample, digital pressed bit, millisecond time stamp, force-report and
// report-enable bits. The output channel (out_valid / out_stall) returns one
// beat per poll with the held axis value, a centered flag, the report flag
// and an echo of the raw sample.
// A poll that must go through the linear map passes the setup, multiply,
// divide and finish states from its acceptance to its result; the time is set
// by the bit-serial divider, which retires one quotient bit per cycle over a
// 34-bit dividend. Polls that end in a fixed value (button mode, deadzone,
// clamp below the trigger start, zero span) skip the multiply and divide states.
// A new poll is taken in the cycle after a result enters the output register; a poll is not taken while one is in work.
// The output register holds a finished result while out_stall is high; the
// block still takes the next poll, and waits before its own finish if the
// earlier result has not been taken.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) and must
// be written only while the block is idle.
// A synchronous reset loads the register defaults, clears the held value,
// the time stamp and the last reported values, and drops out_valid.
module axis_calibrate_deadzone_debounce import acdd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [VALW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [VALW-1:0] raw_sample,
  input  logic            digital_pressed,
  input  logic [31:0]     now_ms,
  input  logic            force_report,
  input  logic            report_enable,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [VALW-1:0] axis_value,
  output logic            is_centered,
  output logic            report_valid,
  output logic [VALW-1:0] raw_echo
);

  // Configuration registers.
  logic [VALW-1:0] range_min, range_max, center_value, deadzone_width;
  logic [VALW-1:0] debounce_ms, pressed_value, released_value;
  logic [4:0]      mode_flags;

  // Block state carried from poll to poll.
  logic [VALW-1:0] held_value;
  logic [31:0]     last_active_ms;
  logic [VALW-1:0] last_reported_raw;
  logic [VALW-1:0] last_reported_value;

  // The accepted poll.
  logic [VALW-1:0] p_raw;
  logic            p_pressed;
  logic [31:0]     p_now;
  logic            p_full;
  logic            p_rep_en;

  // Operands prepared in the setup step.
  logic                   direct;
  logic [VALW-1:0]        direct_val;
  logic signed [OPW-1:0]  xa;
  logic signed [OPW-1:0]  den;
  logic                   c_half;
  logic                   q_neg;
  acdd_span_t             span;

  acdd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min      <= '0;
      range_max      <= FULL_SCALE;
      center_value   <= HALF_SCALE;
      deadzone_width <= '0;
      debounce_ms    <= '0;
      pressed_value  <= FULL_SCALE;
      released_value <= '0;
      mode_flags     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_MIN:      range_min      <= cfg_data;
        CFG_RANGE_MAX:      range_max      <= cfg_data;
        CFG_CENTER_VALUE:   center_value   <= cfg_data;
        CFG_DEADZONE_WIDTH: deadzone_width <= cfg_data;
        CFG_DEBOUNCE_MS:    debounce_ms    <= cfg_data;
        CFG_PRESSED_VALUE:  pressed_value  <= cfg_data;
        CFG_RELEASED_VALUE: released_value <= cfg_data;
        CFG_MODE_FLAGS:     mode_flags     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Setup: choose the fixed result or the operands of the linear map
  // c + (x - a) * (d - c) / (b - a). All values are signed so that limits
  // shifted by the deadzone may leave the 16-bit range.
  logic signed [OPW-1:0] v, lo, hi, ctr, dz;
  logic signed [OPW-1:0] lo_pdz, lo_mdz, c_pdz, c_mdz;
  logic signed [OPW-1:0] a_s, b_s, vv_s, xa_s, den_s;
  logic                  inv;
  logic                  dir_s;
  logic [VALW-1:0]       dval_s;
  logic                  chalf_s;
  acdd_span_t            span_s;

  always_comb begin
    v      = OPW'(signed'({1'b0, p_raw}));
    lo     = OPW'(signed'({1'b0, range_min}));
    hi     = OPW'(signed'({1'b0, range_max}));
    ctr    = OPW'(signed'({1'b0, center_value}));
    dz     = OPW'(signed'({1'b0, deadzone_width}));
    lo_pdz = lo + dz;
    lo_mdz = lo - dz;
    c_pdz  = ctr + dz;
    c_mdz  = ctr - dz;
    inv    = range_min > range_max;
    dir_s   = 1'b0;
    dval_s  = '0;
    a_s     = '0;
    b_s     = hi;
    vv_s    = v;
    chalf_s = 1'b0;
    span_s  = SPAN_FULL;
    if (mode_flags[MODE_BUTTON]) begin
      dir_s = 1'b1;
      if (p_pressed) begin
        dval_s = pressed_value;
      end else if (mode_flags[MODE_RELEASED]) begin
        dval_s = released_value;
      end else begin
        dval_s = center_value;
      end
    end else if (mode_flags[MODE_TRIGGER]) begin
      if (!inv) begin
        a_s = lo_pdz;
        if (v < lo_pdz) begin
          dir_s = 1'b1;
        end else if (v > hi) begin
          vv_s = hi;
        end
      end else begin
        a_s = lo_mdz;
        if (v > lo_mdz) begin
          dir_s = 1'b1;
        end else if (v < hi) begin
          vv_s = hi;
        end
      end
    end else if (v < ctr) begin
      if (ctr - v < dz) begin
        dir_s  = 1'b1;
        dval_s = HALF_SCALE;
      end else if (inv) begin
        a_s     = c_mdz;
        chalf_s = 1'b1;
        span_s  = SPAN_HALF_UP;
      end else begin
        a_s    = lo;
        b_s    = c_mdz;
        span_s = SPAN_HALF_LO;
      end
    end else begin
      if (v - ctr < dz) begin
        dir_s  = 1'b1;
        dval_s = HALF_SCALE;
      end else if (inv) begin
        a_s    = lo;
        b_s    = c_pdz;
        span_s = SPAN_HALF_LO;
      end else begin
        a_s     = c_pdz;
        chalf_s = 1'b1;
        span_s  = SPAN_HALF_UP;
      end
    end
    xa_s  = vv_s - a_s;
    den_s = b_s - a_s;
    // A zero span maps to full scale.
    if (!dir_s && den_s == '0) begin
      dir_s  = 1'b1;
      dval_s = FULL_SCALE;
    end
  end

  // Multiply step: magnitudes go to the divider, the sign is kept aside.
  logic [MAGW-1:0] xmag, dmag;
  logic [VALW-1:0] span_k;
  logic [NUMW-1:0] prod;
  logic            div_start;
  logic            div_done;
  logic [NUMW-1:0] quo;

  always_comb begin
    xmag = xa[OPW-1]  ? MAGW'(-xa)  : MAGW'(xa);
    dmag = den[OPW-1] ? MAGW'(-den) : MAGW'(den);
    case (span)
      SPAN_HALF_LO: span_k = HALF_SCALE;
      SPAN_HALF_UP: span_k = HALF_UP;
      default:      span_k = FULL_SCALE;
    endcase
    prod      = NUMW'(xmag) * NUMW'(span_k);
    div_start = (state == ST_MUL);
  end

  acdd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (dmag),
    .done  (div_done),
    .quo   (quo)
  );

  // Finish: apply sign and offset, saturate, then update the held value.
  logic signed [SUMW-1:0] sq, sum;
  logic [VALW-1:0]        val;
  logic [VALW-1:0]        held_new;
  logic [31:0]            elapsed;
  logic                   active;
  logic                   report;
  logic                   out_free;
  logic                   finish;

  always_comb begin
    sq  = q_neg ? -SUMW'(signed'({2'b0, quo})) : SUMW'(signed'({2'b0, quo}));
    sum = sq + (c_half ? SUMW'(signed'({1'b0, HALF_SCALE})) : SUMW'(0));
    if (direct) begin
      val = direct_val;
    end else if (sum < 0) begin
      val = '0;
    end else if (sum > SUMW'(signed'({1'b0, FULL_SCALE}))) begin
      val = FULL_SCALE;
    end else begin
      val = sum[VALW-1:0];
    end
    elapsed  = p_now - last_active_ms;
    active   = (val != center_value);
    held_new = held_value;
    if (active) begin
      if (!mode_flags[MODE_PEAK] || val > held_value) begin
        held_new = val;
      end
    end else if (!mode_flags[MODE_DEBOUNCE] || elapsed > {16'd0, debounce_ms}) begin
      held_new = val;
    end
    report = p_rep_en && (p_raw != last_reported_raw ||
                          held_new != last_reported_value || p_full);
    out_free = !out_valid || !out_stall;
    finish   = (state == ST_FIN) && out_free;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = dir_s ? ST_FIN : ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Poll capture and operand registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      p_raw     <= raw_sample;
      p_pressed <= digital_pressed;
      p_now     <= now_ms;
      p_full    <= force_report;
      p_rep_en  <= report_enable;
    end
    if (state == ST_SETUP) begin
      direct     <= dir_s;
      direct_val <= dval_s;
      xa         <= xa_s;
      den        <= den_s;
      c_half     <= chalf_s;
      span       <= span_s;
      q_neg      <= xa_s[OPW-1] ^ den_s[OPW-1];
    end
  end

  // Block state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_value          <= '0;
      last_active_ms      <= '0;
      last_reported_raw   <= '0;
      last_reported_value <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (finish) begin
        held_value <= held_new;
        if (active) begin
          last_active_ms <= p_now;
        end
        if (report) begin
          last_reported_raw   <= p_raw;
          last_reported_value <= held_new;
        end
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      axis_value   <= held_new;
      is_centered  <= (held_new == center_value);
      report_valid <= report;
      raw_echo     <= p_raw;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/acdd_checker.sv =====
`default_nettype none
`include "axis_calibrate_deadzone_debounce_assert.svh"
module acdd_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] axis_value,
  input wire        report_valid,
  input wire [15:0] raw_echo
);

  // A stalled result beat keeps its payload.
  `ACDD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(axis_value) && $stable(raw_echo) && $stable(report_valid), "stalled result changed")

  // Only one poll is in work at a time.
  `ACDD_ASSERT_NEXT(a_one_poll, in_valid && !in_stall, in_stall, "poll accepted while busy")

  // A result is registered only after the setup state of its poll.
  `ACDD_ASSERT_NEXT(a_min_lat, in_valid && !in_stall && !out_valid, !out_valid, "result too early")

  // Reset leaves the block empty and ready.
  `ACDD_ASSERT_NEXT(a_reset, rst, !out_valid && !in_stall, "bad state after reset")

endmodule

bind axis_calibrate_deadzone_debounce acdd_checker u_acdd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .axis_value   (axis_value),
  .report_valid (report_valid),
  .raw_echo     (raw_echo)
);
`default_nettype wire
